/* src/kflv_pkg.sv */
// ----------------------------------------------------------------------------
// kflv_pkg
// shared codes, fixed field widths and the command word passed from the
// front end through the queue to the back end of the keyframe interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package kflv_pkg;

  // fixed field widths
  localparam int VAL_W      = 16;  // one vector component, signed fixed point
  localparam int AGE_W      = 16;  // age field
  localparam int IDX_W      = 4;   // frame_index field
  localparam int CNT_W      = 5;   // frame_count register
  localparam int ADDR_MAX_W = 8;   // table address, enough for 256 frames
  localparam int FRAC_MAX_W = 25;  // interpolation weight, up to 24 fraction bits plus one

  // item codes on the input side
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // command kinds after classification
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;  // write one table slot
  localparam logic [KIND_W-1:0] KIND_PASS = 2'd1;  // empty table, scale passes through
  localparam logic [KIND_W-1:0] KIND_LERP = 2'd2;  // interpolate between two slots

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // classified command; vx..vz carry the frame for a load, the scale otherwise
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ADDR_MAX_W-1:0] addr0;
    logic [ADDR_MAX_W-1:0] addr1;
    logic [FRAC_MAX_W-1:0] frac;
    logic [VAL_W-1:0]      vx;
    logic [VAL_W-1:0]      vy;
    logic [VAL_W-1:0]      vz;
    logic                  last;
  } cmd_t;

endpackage

`default_nettype wire

/* src/keyframe_lerp_vec3.sv */
// ----------------------------------------------------------------------------
// keyframe_lerp_vec3
// keyframe table with linear interpolation over a normalized age and a
// per-item three-component multiplier, saturated to 16-bit fixed point
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                      beat taken when
//  s_axis    in   tvalid tready tdata tuser    tvalid && tready
//                 tlast
//  m_axis    out  tvalid tready tdata tuser    tvalid && tready
//                 tlast
//  apb       in   psel penable pwrite paddr    psel && penable && pwrite
//                 pwdata prdata pready         (pready tied high)
//
//  one beat per cycle sustained in both directions while m_axis is not stalled;
//  an evaluate beat passes through the queue, table read, weight multiply,
//  sum and scale multiply, then sits in the output register
//  a load beat writes the table in the cycle it leaves the queue and gives no
//  result; it takes one slot of the pipeline
//  reset clears frame_count, the queue and all valid flags; table contents
//  are undefined until loaded
//  a stall on m_axis freezes the back end; the four-entry queue keeps
//  s_axis open until it fills
//
`default_nettype none

module keyframe_lerp_vec3 #(
  parameter int MAX_FRAMES      = 16,
  parameter int AGE_FRAC_BITS   = 16,
  parameter int VALUE_FRAC_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,

  // input beats
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // frame_index[3:0], frame_x[19:4], frame_y[35:20], frame_z[51:36],
  // age[67:52], scale_x[83:68], scale_y[99:84], scale_z[115:100], zero fill
  input  wire logic [119:0] s_axis_tdata,
  // op[0]
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,

  // result beats
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_x[15:0], out_y[31:16], out_z[47:32]
  output logic [47:0]       m_axis_tdata,
  // clipped[0]
  output logic [0:0]        m_axis_tuser,
  output logic              m_axis_tlast,

  // register port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // register map
  localparam logic ADDR_FRAME_COUNT = 1'b0;  // paddr[2] selects the word

  logic [kflv_pkg::CNT_W-1:0] frame_count;
  logic                       reg_wr;

  logic                       push;
  logic                       q_full;
  logic                       q_valid;
  logic                       pop;
  kflv_pkg::cmd_t             cmd_in;
  kflv_pkg::cmd_t             cmd_head;

  logic [15:0]                out_x;
  logic [15:0]                out_y;
  logic [15:0]                out_z;
  logic                       clipped;
  logic                       last_out;

  // register port: always ready, write on the access cycle
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_FRAME_COUNT) ?
                  {{(32 - kflv_pkg::CNT_W){1'b0}}, frame_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (reg_wr && (paddr[2] == ADDR_FRAME_COUNT)) begin
      frame_count <= pwdata[kflv_pkg::CNT_W-1:0];
    end
  end

  // front end: classify, scale the age, pick the pair
  kflv_front #(
    .MAX_FRAMES   (MAX_FRAMES),
    .AGE_FRAC_BITS(AGE_FRAC_BITS)
  ) u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser[0]),
    .frame_index(s_axis_tdata[3:0]),
    .frame_x    (s_axis_tdata[19:4]),
    .frame_y    (s_axis_tdata[35:20]),
    .frame_z    (s_axis_tdata[51:36]),
    .age        (s_axis_tdata[67:52]),
    .scale_x    (s_axis_tdata[83:68]),
    .scale_y    (s_axis_tdata[99:84]),
    .scale_z    (s_axis_tdata[115:100]),
    .last_in    (s_axis_tlast),
    .frame_count(frame_count),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd_in)
  );

  // decoupling queue
  kflv_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd_in),
    .full   (q_full),
    .pop    (pop),
    .valid  (q_valid),
    .cmd_out(cmd_head)
  );

  // back end: table, interpolation and scaling pipeline, output register
  kflv_back #(
    .MAX_FRAMES     (MAX_FRAMES),
    .AGE_FRAC_BITS  (AGE_FRAC_BITS),
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (cmd_head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .clipped  (clipped),
    .last_out (last_out)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};
  assign m_axis_tuser = clipped;
  assign m_axis_tlast = last_out;

endmodule

`default_nettype wire

/* src/kflv_front.sv */
// ----------------------------------------------------------------------------
// kflv_front
// classifies input items, scales the age by one less than the frame count and picks the
// pair of slots and the interpolation weight
// ----------------------------------------------------------------------------
`default_nettype none

module kflv_front #(
  parameter int MAX_FRAMES    = 16,
  parameter int AGE_FRAC_BITS = 16
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [kflv_pkg::IDX_W-1:0]    frame_index,
  input  wire logic [kflv_pkg::VAL_W-1:0]    frame_x,
  input  wire logic [kflv_pkg::VAL_W-1:0]    frame_y,
  input  wire logic [kflv_pkg::VAL_W-1:0]    frame_z,
  input  wire logic [kflv_pkg::AGE_W-1:0]    age,
  input  wire logic [kflv_pkg::VAL_W-1:0]    scale_x,
  input  wire logic [kflv_pkg::VAL_W-1:0]    scale_y,
  input  wire logic [kflv_pkg::VAL_W-1:0]    scale_z,
  input  wire logic                          last_in,
  input  wire logic [kflv_pkg::CNT_W-1:0]    frame_count,
  input  wire logic                          q_full,
  output logic                               push,
  output kflv_pkg::cmd_t                     cmd
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int PW = kflv_pkg::AGE_W + NW;
  localparam int XW = PW + AGE_FRAC_BITS;

  logic [NW-1:0] n;
  logic [PW-1:0] prod;
  logic [XW-1:0] prod_x;
  logic [XW-1:0] ci_raw;
  logic [XW-1:0] last_pair;
  logic [IW-1:0] ci;
  logic          slot_ok;

  always_comb begin
    n = (32'(frame_count) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(frame_count);
    // age times (frames - 1): integer part picks the pair
    prod      = PW'(age) * PW'(n - NW'(1));
    prod_x    = XW'(prod);
    ci_raw    = prod_x >> AGE_FRAC_BITS;
    last_pair = XW'(n) - XW'(2);
    slot_ok   = 32'(frame_index) < 32'(MAX_FRAMES);

    cmd      = '0;
    cmd.last = last_in;
    cmd.vx   = scale_x;
    cmd.vy   = scale_y;
    cmd.vz   = scale_z;
    ci       = '0;

    if (op == kflv_pkg::OP_LOAD) begin
      cmd.kind  = kflv_pkg::KIND_LOAD;
      cmd.addr0 = kflv_pkg::ADDR_MAX_W'(frame_index);
      cmd.vx    = frame_x;
      cmd.vy    = frame_y;
      cmd.vz    = frame_z;
    end else if (n == '0) begin
      cmd.kind = kflv_pkg::KIND_PASS;
    end else begin
      cmd.kind = kflv_pkg::KIND_LERP;
      if (n == NW'(1)) begin
        // single frame: weight zero on slot 0 against itself
        ci        = '0;
        cmd.frac  = '0;
        cmd.addr0 = '0;
        cmd.addr1 = '0;
      end else begin
        if (ci_raw > last_pair) begin
          // age of one or more: last pair at full weight
          ci       = IW'(last_pair);
          cmd.frac = kflv_pkg::FRAC_MAX_W'({1'b1, {AGE_FRAC_BITS{1'b0}}});
        end else begin
          ci       = IW'(ci_raw);
          cmd.frac = kflv_pkg::FRAC_MAX_W'({1'b0, prod_x[AGE_FRAC_BITS-1:0]});
        end
        cmd.addr0 = kflv_pkg::ADDR_MAX_W'(ci);
        cmd.addr1 = kflv_pkg::ADDR_MAX_W'(IW'(ci + IW'(1)));
      end
    end
  end

  assign in_ready = !q_full;
  // loads outside the table are dropped here
  assign push     = in_valid && !q_full && ((op == kflv_pkg::OP_EVAL) || slot_ok);

endmodule

`default_nettype wire

/* src/kflv_queue.sv */
// ----------------------------------------------------------------------------
// kflv_queue
// short command queue between the front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module kflv_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kflv_pkg::cmd_t cmd_in,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output kflv_pkg::cmd_t      cmd_out
);

  kflv_pkg::cmd_t                    slots [kflv_pkg::QUEUE_DEPTH];
  logic [kflv_pkg::QPTR_W-1:0]       wr_ptr;
  logic [kflv_pkg::QPTR_W-1:0]       rd_ptr;
  logic [kflv_pkg::QCNT_W-1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kflv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + kflv_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + kflv_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - kflv_pkg::QCNT_W'(1);
      end
    end
  end

  assign full    = (count == kflv_pkg::QCNT_W'(kflv_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = slots[rd_ptr];

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + kflv_pkg::QCNT_W'(1)))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == kflv_pkg::QPTR_W'(count))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* src/kflv_back.sv */
// ----------------------------------------------------------------------------
// kflv_back
// keyframe table and the interpolate, scale, round and saturate pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module kflv_back #(
  parameter int MAX_FRAMES      = 16,
  parameter int AGE_FRAC_BITS   = 16,
  parameter int VALUE_FRAC_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire kflv_pkg::cmd_t             q_cmd,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [kflv_pkg::VAL_W-1:0]      out_x,
  output logic [kflv_pkg::VAL_W-1:0]      out_y,
  output logic [kflv_pkg::VAL_W-1:0]      out_z,
  output logic                            clipped,
  output logic                            last_out
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int A  = AGE_FRAC_BITS;
  localparam int FW = A + 1;              // weight, up to exactly one
  localparam int PW = FW + 18;            // weight times difference
  localparam int SW = A + 20;             // sum before trimming
  localparam int VW = A + 16;             // interpolated value, A fraction bits
  localparam int MW = VW + 16;            // scaled value, A + V fraction bits
  localparam int SH = A + VALUE_FRAC_BITS;
  localparam int EW = 3 * kflv_pkg::VAL_W;

  localparam logic signed [MW:0] HALF   = {{MW{1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [MW:0] SAT_HI = 32767;
  localparam logic signed [MW:0] SAT_LO = -32768;

  logic advance;
  logic is_load;

  // keyframe table, one word per slot: z, y, x from the top
  logic [EW-1:0] table_mem [MAX_FRAMES];
  logic [EW-1:0] rd0;
  logic [EW-1:0] rd1;

  // stage 1: table read
  logic                      v1, pass1, last1;
  logic [FW-1:0]             frac1;
  logic signed [15:0]        sc1 [3];
  // stage 2: weight times difference
  logic                      v2, pass2, last2;
  logic signed [15:0]        sc2 [3];
  logic signed [15:0]        k0_2 [3];
  logic signed [PW-1:0]      p2 [3];
  // stage 3: interpolated value
  logic                      v3, pass3, last3;
  logic signed [15:0]        sc3 [3];
  logic signed [VW-1:0]      vv3 [3];
  // stage 4: scaled value
  logic                      v4, pass4, last4;
  logic signed [15:0]        sc4 [3];
  logic signed [MW-1:0]      m4 [3];

  logic signed [15:0]        k0 [3];
  logic signed [15:0]        k1 [3];
  logic signed [16:0]        dk [3];
  logic signed [PW-1:0]      pc [3];
  logic signed [SW-1:0]      sc_sum [3];
  logic signed [MW-1:0]      mc [3];
  logic signed [MW:0]        rnd [3];
  logic signed [MW:0]        rsh [3];
  logic [15:0]               res [3];
  logic [2:0]                sat;

  assign advance = !out_valid || out_ready;
  assign pop     = q_valid && advance;
  assign is_load = (q_cmd.kind == kflv_pkg::KIND_LOAD);

  always_ff @(posedge clk) begin
    if (pop && is_load) begin
      table_mem[q_cmd.addr0[IW-1:0]] <= {q_cmd.vz, q_cmd.vy, q_cmd.vx};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd0 <= table_mem[q_cmd.addr0[IW-1:0]];
      rd1 <= table_mem[q_cmd.addr1[IW-1:0]];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      k0[c]     = $signed(rd0[c*16 +: 16]);
      k1[c]     = $signed(rd1[c*16 +: 16]);
      dk[c]     = 17'(k1[c]) - 17'(k0[c]);
      pc[c]     = $signed({1'b0, frac1}) * dk[c];
      sc_sum[c] = (SW'(k0_2[c]) <<< A) + SW'(p2[c]);
      mc[c]     = vv3[c] * sc3[c];
      rnd[c]    = (MW + 1)'(m4[c]) + HALF;
      rsh[c]    = rnd[c] >>> SH;
      sat[c]    = 1'b0;
      if (rsh[c] > SAT_HI) begin
        res[c] = 16'h7fff;
        sat[c] = 1'b1;
      end else if (rsh[c] < SAT_LO) begin
        res[c] = 16'h8000;
        sat[c] = 1'b1;
      end else begin
        res[c] = rsh[c][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= pop && !is_load;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pass1 <= (q_cmd.kind == kflv_pkg::KIND_PASS);
      last1 <= q_cmd.last;
      frac1 <= q_cmd.frac[FW-1:0];
      sc1[0] <= $signed(q_cmd.vx);
      sc1[1] <= $signed(q_cmd.vy);
      sc1[2] <= $signed(q_cmd.vz);

      pass2 <= pass1;
      last2 <= last1;
      pass3 <= pass2;
      last3 <= last2;
      pass4 <= pass3;
      last4 <= last3;
      for (int c = 0; c < 3; c++) begin
        sc2[c]  <= sc1[c];
        k0_2[c] <= k0[c];
        p2[c]   <= pc[c];
        sc3[c]  <= sc2[c];
        vv3[c]  <= sc_sum[c][VW-1:0];
        sc4[c]  <= sc3[c];
        m4[c]   <= mc[c];
      end

      last_out <= last4;
      if (pass4) begin
        out_x   <= sc4[0];
        out_y   <= sc4[1];
        out_z   <= sc4[2];
        clipped <= 1'b0;
      end else begin
        out_x   <= res[0];
        out_y   <= res[1];
        out_z   <= res[2];
        clipped <= |sat;
      end
    end
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!advance && v4) |=> v4)
    else $error("stalled stage lost its item");
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (pop && is_load) |=> !v1)
    else $error("load entered the result pipeline");
  a_eval_enters: assert property (@(posedge clk) disable iff (rst)
    (pop && !is_load) |=> v1)
    else $error("evaluate item dropped at table read");
`endif

endmodule

`default_nettype wire
